FILE: rtl/core/gtss_pkg.sv
package gtss_pkg;

   // Command codes carried in the request
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   localparam int CMD_BITS   = 2;
   localparam int LEVEL_BITS = 8;

   // Levels at or below this are global writes
   localparam logic [LEVEL_BITS-1:0] GLOBAL_LEVEL = 8'd1;

   // Default parameter values
   localparam int DEF_INDEX_BITS  = 12;
   localparam int DEF_STACK_DEPTH = 256;
   localparam int DEF_VALUE_BITS  = 32;

   // Control handed to every stack cell
   typedef struct packed {
      logic push;
      logic pop;
      logic kill;
   } stack_ctrl_type;

endpackage

FILE: rtl/core/gtss_ram.sv
module gtss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/gtss_cell.sv
module gtss_cell #(
   parameter int INDEX_BITS = gtss_pkg::DEF_INDEX_BITS,
   parameter int ENTRY_BITS = 16
) (
   input  logic                       clock,
   input  gtss_pkg::stack_ctrl_type   ctrl,
   input  logic [INDEX_BITS-1:0]      kill_index,
   input  logic [ENTRY_BITS-1:0]      from_above,
   input  logic [ENTRY_BITS-1:0]      from_below,
   output logic [ENTRY_BITS-1:0]      entry
);

   // Entry layout: {live, level, value, index}, index in the low bits
   logic [ENTRY_BITS-1:0] entry_ff;
   logic [ENTRY_BITS-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         entry_in = from_above;
      end else if (ctrl.pop) begin
         entry_in = from_below;
      end else if (ctrl.kill && (entry_ff[INDEX_BITS-1:0] == kill_index)) begin
         entry_in[ENTRY_BITS-1] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/core/gtss_stack.sv
module gtss_stack #(
   parameter int INDEX_BITS  = gtss_pkg::DEF_INDEX_BITS,
   parameter int STACK_DEPTH = gtss_pkg::DEF_STACK_DEPTH,
   parameter int ENTRY_BITS  = 16
) (
   input  logic                     clock,
   input  gtss_pkg::stack_ctrl_type ctrl,
   input  logic [INDEX_BITS-1:0]    kill_index,
   input  logic [ENTRY_BITS-1:0]    push_entry,
   output logic [ENTRY_BITS-1:0]    top_entry
);

   logic [ENTRY_BITS-1:0] chain [STACK_DEPTH];

   // Cell 0 is the top; a push shifts the row down, a pop shifts it up
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [ENTRY_BITS-1:0] above;
      logic [ENTRY_BITS-1:0] below;
      if (i == 0) begin : g_first
         assign above = push_entry;
      end else begin : g_mid
         assign above = chain[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = '0;
      end else begin : g_inner
         assign below = chain[i+1];
      end
      gtss_cell #(
         .INDEX_BITS(INDEX_BITS),
         .ENTRY_BITS(ENTRY_BITS)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .kill_index(kill_index),
         .from_above(above),
         .from_below(below),
         .entry     (chain[i])
      );
   end

   assign top_entry = chain[0];

endmodule

FILE: rtl/core/grouped_table_with_save_stack.sv
// Grouped value table with a save stack. A read returns one entry; a write at
// level 1 or below is global and kills every saved copy of that index; a
// write at a higher level saves the old value on the stack first (overflow
// is flagged when the stack is full and the save is lost); an end group pops
// and restores live entries while the top level is at least the given level.
// Timing: a read, a write or an unused command goes from accept through S_LOOK
// (table lookup through the registered read port of the table RAM) to S_DONE,
// which waits for the output register to be free and loads it; the next
// request can be taken in the cycle the result is presented. An end group
// pops entries in S_POP, as the stack cells restore through the single table
// write port, then goes through S_DONE. A finished result waits in an output
// register while the next transaction is taken. After reset the block sweeps
// the table, one entry a cycle, over all 2**INDEX_BITS entries (4096 by
// default) before it accepts a request; csr writes are taken at any time.
module grouped_table_with_save_stack #(
   parameter int INDEX_BITS  = gtss_pkg::DEF_INDEX_BITS,
   parameter int STACK_DEPTH = gtss_pkg::DEF_STACK_DEPTH,
   parameter int VALUE_BITS  = gtss_pkg::DEF_VALUE_BITS,
   localparam int REQ_BITS   = gtss_pkg::CMD_BITS + INDEX_BITS + VALUE_BITS
                               + gtss_pkg::LEVEL_BITS,
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_W      = ((VALUE_BITS + 1 + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request: cmd, index, value, level (from bit 0 up)
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   // Response: read_value, overflow (from bit 0 up)
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   // Default value register
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [VALUE_BITS-1:0] csr_data
);

   localparam int LB         = gtss_pkg::LEVEL_BITS;
   localparam int ENTRY_BITS = INDEX_BITS + VALUE_BITS + LB + 1;
   localparam int TOP_BITS   = $clog2(STACK_DEPTH + 1);
   localparam int TABLE_SIZE = 1 << INDEX_BITS;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_LOOK  = 5'b00100,
      S_POP   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [INDEX_BITS-1:0]   clr_ff, clr_in;
   logic [TOP_BITS-1:0]     top_ff, top_in;
   logic [VALUE_BITS-1:0]   default_ff;
   logic [1:0]              cmd_ff, cmd_in;
   logic [INDEX_BITS-1:0]   idx_ff, idx_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic [LB-1:0]           lvl_ff, lvl_in;
   logic [VALUE_BITS-1:0]   rd_ff, rd_in;
   logic                    ovf_ff, ovf_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic                    wr_en;
   logic [INDEX_BITS-1:0]   wr_addr;
   logic [VALUE_BITS:0]     wr_data;
   logic [VALUE_BITS:0]     rd_data;
   logic [VALUE_BITS-1:0]   old_value;
   logic                    req_take;
   logic                    slot_free;

   gtss_pkg::stack_ctrl_type ctrl;
   logic [ENTRY_BITS-1:0]    push_entry;
   logic [ENTRY_BITS-1:0]    top_entry;
   logic [INDEX_BITS-1:0]    top_index;
   logic [VALUE_BITS-1:0]    top_value;
   logic [LB-1:0]            top_level;
   logic                     top_live;

   // Table: bit VALUE_BITS marks an entry written since reset
   gtss_ram #(
      .WIDTH(VALUE_BITS + 1),
      .DEPTH(TABLE_SIZE)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(req_tdata[gtss_pkg::CMD_BITS +: INDEX_BITS]),
      .rd_data(rd_data)
   );

   gtss_stack #(
      .INDEX_BITS (INDEX_BITS),
      .STACK_DEPTH(STACK_DEPTH),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_stack (
      .clock     (clock),
      .ctrl      (ctrl),
      .kill_index(idx_ff),
      .push_entry(push_entry),
      .top_entry (top_entry)
   );

   assign top_index = top_entry[INDEX_BITS-1:0];
   assign top_value = top_entry[INDEX_BITS +: VALUE_BITS];
   assign top_level = top_entry[INDEX_BITS + VALUE_BITS +: LB];
   assign top_live  = top_entry[ENTRY_BITS-1];

   assign old_value  = rd_data[VALUE_BITS] ? rd_data[VALUE_BITS-1:0] : default_ff;
   assign push_entry = {1'b1, lvl_ff, old_value, idx_ff};

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      top_in       = top_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      lvl_in       = lvl_ff;
      rd_in        = rd_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = {1'b1, val_ff};
      ctrl         = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == {INDEX_BITS{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               cmd_in = req_tdata[gtss_pkg::CMD_BITS-1:0];
               idx_in = req_tdata[gtss_pkg::CMD_BITS +: INDEX_BITS];
               val_in = req_tdata[gtss_pkg::CMD_BITS + INDEX_BITS +: VALUE_BITS];
               lvl_in = req_tdata[gtss_pkg::CMD_BITS + INDEX_BITS + VALUE_BITS +: LB];
               rd_in  = '0;
               ovf_in = 1'b0;
               if (req_tdata[gtss_pkg::CMD_BITS-1:0] == gtss_pkg::CMD_END) begin
                  state_in = S_POP;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            case (cmd_ff)
               gtss_pkg::CMD_READ: begin
                  rd_in = old_value;
               end
               gtss_pkg::CMD_WRITE: begin
                  wr_en = 1'b1;
                  if (lvl_ff <= gtss_pkg::GLOBAL_LEVEL) begin
                     ctrl.kill = 1'b1;
                  end else if (top_ff != TOP_BITS'(STACK_DEPTH)) begin
                     ctrl.push = 1'b1;
                     top_in    = top_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            state_in = S_DONE;
         end
         S_POP: begin
            if ((top_ff != '0) && (top_level >= lvl_ff)) begin
               ctrl.pop = 1'b1;
               top_in   = top_ff - 1'b1;
               wr_en    = top_live;
               wr_addr  = top_index;
               wr_data  = {1'b1, top_value};
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         default_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            default_ff <= csr_data;
         end
      end
   end

   // Transaction payload
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      lvl_ff       <= lvl_in;
      rd_ff        <= rd_in;
      ovf_ff       <= ovf_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_ovf_ff, rsp_value_ff});

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int IDX_W    = 12;
   localparam int VAL_W    = 32;
   localparam int DEPTH    = 256;
   localparam int REQ_W    = 56;
   localparam int RSP_W    = 40;
   localparam int N_RANDOM = 770;
   localparam int LIMIT    = 2000000;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic [7:0]       level;
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] index;
      logic [1:0]       cmd;
   } request_type;

   typedef struct packed {
      logic             overflow;
      logic [VAL_W-1:0] read_value;
   } outcome_type;

   // Directed row: whether its outcome is written out, and that outcome
   typedef struct {
      request_type req;
      bit          fixed;
      outcome_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [VAL_W-1:0] csr_data = '0;

   grouped_table_with_save_stack uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Shadow of the table and save stack
   logic [VAL_W-1:0] entries [4096];
   bit               written [4096];
   logic [IDX_W-1:0] sv_index [DEPTH];
   logic [VAL_W-1:0] sv_value [DEPTH];
   logic [7:0]       sv_level [DEPTH];
   bit               sv_live [DEPTH];
   int               depth_used;
   logic [VAL_W-1:0] default_val;

   outcome_type pending_outcomes[$];
   int  mismatches = 0;
   int  row_errors = 0;
   int  stall_left = 0;
   bit  calm = 1'b0;    // no idling in the final stretch
   longint cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [VAL_W-1:0] lookup(logic [IDX_W-1:0] i);
      return written[i] ? entries[i] : default_val;
   endfunction

   function automatic outcome_type apply_request(request_type r);
      outcome_type o;
      int k;
      o = '0;
      case (r.cmd)
         gtss_pkg::CMD_READ: o.read_value = lookup(r.index);
         gtss_pkg::CMD_WRITE: begin
            if (r.level <= gtss_pkg::GLOBAL_LEVEL) begin
               for (k = 0; k < depth_used; k++)
                  if (sv_index[k] == r.index) sv_live[k] = 0;
            end else if (depth_used < DEPTH) begin
               sv_index[depth_used] = r.index;
               sv_value[depth_used] = lookup(r.index);
               sv_level[depth_used] = r.level;
               sv_live[depth_used] = 1;
               depth_used++;
            end else begin
               o.overflow = 1'b1;
            end
            entries[r.index] = r.value;
            written[r.index] = 1;
         end
         gtss_pkg::CMD_END: begin
            while (depth_used > 0 && sv_level[depth_used-1] >= r.level) begin
               k = depth_used - 1;
               if (sv_live[k]) begin
                  entries[sv_index[k]] = sv_value[k];
                  written[sv_index[k]] = 1;
               end
               depth_used = k;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Response side: stall bursts, compare against oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction %h", rsp_tdata);
            end else begin
               outcome_type w, got;
               w = pending_outcomes.pop_front();
               got = rsp_tdata[VAL_W:0];
               if (got.read_value !== w.read_value || got.overflow !== w.overflow) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: read_value exp %h got %h, overflow exp %b got %b",
                              w.read_value, got.read_value, w.overflow, got.overflow);
               end
            end
         end
         if (calm) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= int'($urandom_range(1, 6));
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send(request_type r, bit fixed, outcome_type want);
      int gap;
      outcome_type o;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'(r);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      o = apply_request(r);
      if (fixed && o !== want) begin
         row_errors++;
         if (row_errors <= 10)
            $display("table row disagrees: exp %h predicted %h", want, o);
      end
      pending_outcomes.push_back(fixed ? want : o);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_default(logic [VAL_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      default_val = v;
   endtask

   function automatic request_type mk(logic [1:0] c, int i, logic [31:0] v, int l);
      request_type r;
      r.cmd = c; r.index = IDX_W'(i); r.value = v; r.level = 8'(l);
      return r;
   endfunction

   function automatic request_type random_request(int lo_idx, int hi_idx);
      request_type r;
      int p;
      p = $urandom_range(0, 99);
      r.index = IDX_W'($urandom_range(lo_idx, hi_idx));
      r.value = $urandom;
      if (p < 35) begin
         r.cmd = gtss_pkg::CMD_READ; r.level = 8'($urandom);
      end else if (p < 80) begin
         r.cmd = gtss_pkg::CMD_WRITE;
         r.level = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 1))
                                                 : 8'($urandom_range(2, 255));
      end else if (p < 97) begin
         r.cmd = gtss_pkg::CMD_END;
         r.level = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(2, 255));
      end else begin
         r.cmd = CMD_SPARE; r.level = 8'($urandom);
      end
      return r;
   endfunction

   initial begin
      row_type rows[$];
      outcome_type none;
      int n;
      depth_used = 0;
      default_val = '0;
      for (n = 0; n < 4096; n++) begin
         written[n] = 0;
         entries[n] = '0;
      end
      none = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      rows.push_back('{mk(gtss_pkg::CMD_READ, 0, 0, 0), 1, '{1'b0, 32'd0}});
      rows.push_back('{mk(gtss_pkg::CMD_READ, 4095, 32'hFFFF_FFFF, 255), 1,
                       '{1'b0, 32'd0}});
      rows.push_back('{mk(gtss_pkg::CMD_WRITE, 4095, 32'h7FFF_FFFF, 1), 1, none});
      rows.push_back('{mk(gtss_pkg::CMD_READ, 4095, 0, 0), 1, '{1'b0, 32'h7FFF_FFFF}});
      rows.push_back('{mk(gtss_pkg::CMD_WRITE, 0, 32'h8000_0000, 0), 1, none});
      rows.push_back('{mk(gtss_pkg::CMD_END, 0, 0, 0), 1, none});
      rows.push_back('{mk(gtss_pkg::CMD_WRITE, 5, 32'h1111, 2), 1, none});
      rows.push_back('{mk(gtss_pkg::CMD_WRITE, 5, 32'h2222, 255), 1, none});
      rows.push_back('{mk(gtss_pkg::CMD_WRITE, 6, 32'h3333, 3), 1, none});
      rows.push_back('{mk(gtss_pkg::CMD_WRITE, 6, 32'h4444, 1), 1, none});
      rows.push_back('{mk(gtss_pkg::CMD_READ, 5, 0, 0), 0, none});
      rows.push_back('{mk(gtss_pkg::CMD_END, 0, 0, 255), 0, none});
      rows.push_back('{mk(gtss_pkg::CMD_READ, 5, 0, 0), 0, none});
      rows.push_back('{mk(gtss_pkg::CMD_END, 0, 0, 3), 0, none});
      rows.push_back('{mk(gtss_pkg::CMD_READ, 6, 0, 0), 0, none});
      rows.push_back('{mk(gtss_pkg::CMD_END, 0, 0, 0), 0, none});
      rows.push_back('{mk(gtss_pkg::CMD_READ, 5, 0, 0), 0, none});
      rows.push_back('{mk(CMD_SPARE, 4095, 32'hFFFF_FFFF, 255), 1, none});
      foreach (rows[i]) send(rows[i].req, rows[i].fixed, rows[i].want);
      drain();

      // Default changes after use; extremes included
      set_default(32'h8000_0000);
      send(mk(gtss_pkg::CMD_READ, 77, 0, 0), 1, '{1'b0, 32'h8000_0000});
      send(mk(gtss_pkg::CMD_WRITE, 77, 32'h5, 9), 0, none);
      drain();
      set_default(32'h7FFF_FFFF);
      send(mk(gtss_pkg::CMD_END, 0, 0, 0), 0, none);
      send(mk(gtss_pkg::CMD_READ, 77, 0, 0), 0, none);

      // Fill the stack past full
      for (n = 0; n < DEPTH + 4; n++)
         send(mk(gtss_pkg::CMD_WRITE, int'($urandom_range(0, 31)), $urandom,
                 int'($urandom_range(2, 255))), 0, none);
      send(mk(gtss_pkg::CMD_END, 0, 0, 0), 0, none);
      drain();
      set_default($urandom);

      // Random, phases with different defaults; index range varies per request
      for (n = 0; n < N_RANDOM; n++) begin
         if (n % 250 == 249) begin
            drain();
            set_default((n / 250) % 2 ? '0 : $urandom);
         end
         if (n > N_RANDOM - 150) calm = 1;
         send(random_request(0, (n % 3 == 0) ? 4095 : 15), 0, none);
      end
      req_tvalid <= 1'b0;
      drain();

      if (mismatches == 0 && row_errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
